// ----- rtl/core/linear_probe_hash_table_macros.svh -----
// Assertion macros used by the checker file
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Implication checked at every clock edge outside reset
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants for the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned TotalW  = 9;
  localparam int unsigned LimitW  = 9;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvMul   = 32'd16777619;
  localparam logic [LimitW-1:0] LimitReset = 9'd192;

  typedef enum logic [FuncW-1:0] {
    FUNC_FIND    = 2'd0,
    FUNC_INSERT  = 2'd1,
    FUNC_UPSERT  = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  typedef enum logic [StatusW-1:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_REPLACED  = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValW-1:0]    read_value;
    logic [SlotW-1:0]   slot_index;
    logic [TotalW-1:0]  entry_total;
  } rsp_t;

endpackage

// ----- rtl/core/lpht_if.sv -----
// ----------------------------------------------------------------------------
// lpht_req_if / lpht_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  logic                     valid;
  logic                     ready;
  logic [lpht_pkg::FuncW-1:0] func;
  logic [lpht_pkg::KeyW-1:0]  key;
  logic [lpht_pkg::ValW-1:0]  value;
  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

interface lpht_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lpht_pkg::StatusW-1:0] status;
  logic [lpht_pkg::ValW-1:0]    read_value;
  logic [lpht_pkg::SlotW-1:0]   slot_index;
  logic [lpht_pkg::TotalW-1:0]  entry_total;
  modport source (output valid, status, read_value, slot_index, entry_total,
                  input ready);
  modport sink   (input valid, status, read_value, slot_index, entry_total,
                  output ready);
endinterface

// ----- rtl/core/lpht_front.sv -----
// ----------------------------------------------------------------------------
// lpht_front
// Accepts requests, hashes the key one byte a cycle, and pushes the
// classified request with its home slot into a two-entry queue.
// ----------------------------------------------------------------------------
module lpht_front #(
  parameter int unsigned SLOTS     = 256,
  parameter int unsigned KEY_BYTES = 4,
  parameter int unsigned VAL_BYTES = 4,
  localparam int unsigned IdxW     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic clk,
  input  logic rst_n,
  lpht_req_if.sink in_ch,
  output logic                  q_valid,
  input  logic                  q_pop,
  output lpht_pkg::req_t        q_req,
  output logic [IdxW-1:0]       q_home
);
  import lpht_pkg::*;

  localparam int unsigned KB   = (KEY_BYTES < 8) ? KEY_BYTES : 8;
  localparam int unsigned KBW  = $clog2(KB + 1);
  localparam int unsigned KBits = (KB * 8 < KeyW) ? KB * 8 : KeyW;
  localparam int unsigned VBits = (VAL_BYTES * 8 < ValW) ? VAL_BYTES * 8 : ValW;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_HASH = 2'b10
  } fstate_t;

  fstate_t          state_r, state_nxt;
  req_t             req_r;
  logic [31:0]      hash_r, hash_nxt;
  logic [KBW-1:0]   byte_r, byte_nxt;

  // two-entry queue
  req_t             qreq_r [2];
  logic [IdxW-1:0]  qhome_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic [KeyW-1:0]  key_m;
  logic [ValW-1:0]  val_m;
  logic [63:0]      key_ext;
  logic [2:0]       byte_sel;
  logic [7:0]       cur_byte;
  logic [31:0]      hx;
  logic [31:0]      hprod;

  always_comb begin
    key_m = '0;
    key_m[KBits-1:0] = in_ch.key[KBits-1:0];
    val_m = '0;
    val_m[VBits-1:0] = in_ch.value[VBits-1:0];
  end

  // bytes above the key width hash as zero
  assign key_ext     = 64'(req_r.key);
  assign byte_sel    = 3'(byte_r);
  assign in_ch.ready = (state_r == F_IDLE);
  assign cur_byte    = key_ext[{byte_sel, 3'b000} +: 8];
  assign hx          = hash_r ^ {24'd0, cur_byte};
  assign hprod       = hx * FnvMul;
  assign push        = (state_r == F_HASH) && (byte_r == KBW'(KB)) && (cnt_r != 2'd2);

  always_comb begin
    state_nxt = state_r;
    hash_nxt  = hash_r;
    byte_nxt  = byte_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = F_HASH;
          hash_nxt  = FnvBasis;
          byte_nxt  = '0;
        end
      end
      F_HASH: begin
        if (byte_r != KBW'(KB)) begin
          hash_nxt = hprod;
          byte_nxt = byte_r + 1'b1;
        end else if (push) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    byte_r <= byte_nxt;
    if (in_ch.valid && in_ch.ready) begin
      req_r.func  <= in_ch.func;
      req_r.key   <= key_m;
      req_r.value <= val_m;
    end
    if (push) begin
      qreq_r[wp_r]  <= req_r;
      qhome_r[wp_r] <= IdxW'(hash_r % SLOTS);
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = qreq_r[rp_r];
  assign q_home  = qhome_r[rp_r];

endmodule

// ----- rtl/core/lpht_back.sv -----
// ----------------------------------------------------------------------------
// lpht_back
// Carries out find, insert, insert-or-replace and clear against the slot
// memories, one request and one probe read at a time, and holds the result register.
// ----------------------------------------------------------------------------
module lpht_back #(
  parameter int unsigned SLOTS = 256,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned CntW = $clog2(SLOTS + 1)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  lpht_pkg::req_t              q_req,
  input  logic [IdxW-1:0]             q_home,
  input  logic [lpht_pkg::LimitW-1:0] load_limit,
  lpht_rsp_if.source out_ch
);
  import lpht_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_READ  = 5'b00010,
    B_CHECK = 5'b00100,
    B_WIPE  = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_t;

  bstate_t         state_r, state_nxt;
  logic [SLOTS-1:0] used_r;
  logic [KeyW-1:0] key_mem [SLOTS];
  logic [ValW-1:0] val_mem [SLOTS];
  logic [KeyW-1:0] rd_key_r;
  logic [ValW-1:0] rd_val_r;
  logic            rd_used_r;
  req_t            op_r;
  logic [IdxW-1:0] idx_r, home_r;
  logic [CntW-1:0] count_r;
  logic [CntW:0]   probes_r;
  rsp_t            rsp_r;
  logic            ovalid_r;
  logic            wr_en;
  logic            ins_en;
  logic [IdxW-1:0] next_idx;
  logic            at_limit;
  rsp_t            rsp_nxt;
  logic [CntW:0]   lim_eff;

  assign next_idx = (idx_r == IdxW'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign lim_eff  = (32'(load_limit) > SLOTS) ? (CntW+1)'(SLOTS) : (CntW+1)'(load_limit);
  assign at_limit = {1'b0, count_r} >= lim_eff;
  assign q_pop    = (state_r == B_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    ins_en    = 1'b0;
    rsp_nxt   = rsp_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = (func_t'(q_req.func) == FUNC_CLEAR) ? B_WIPE : B_READ;
        end
      end
      B_READ: state_nxt = B_CHECK;
      B_CHECK: begin
        rsp_nxt.read_value  = '0;
        rsp_nxt.slot_index  = '0;
        rsp_nxt.entry_total = TotalW'(count_r);
        if (func_t'(op_r.func) == FUNC_FIND) begin
          if (rd_used_r && rd_key_r == op_r.key) begin
            rsp_nxt.status     = ST_FOUND;
            rsp_nxt.read_value = rd_val_r;
            rsp_nxt.slot_index = SlotW'(idx_r);
            state_nxt = B_OUT;
          end else if (!rd_used_r || next_idx == home_r) begin
            rsp_nxt.status = ST_NOT_FOUND;
            state_nxt = B_OUT;
          end else begin
            state_nxt = B_READ;
          end
        end else begin
          if (!rd_used_r) begin
            if (at_limit) begin
              rsp_nxt.status = ST_FULL;
            end else begin
              ins_en = 1'b1;
              wr_en  = 1'b1;
              rsp_nxt.status      = ST_INSERTED;
              rsp_nxt.slot_index  = SlotW'(idx_r);
              rsp_nxt.entry_total = TotalW'(count_r + 1'b1);
            end
            state_nxt = B_OUT;
          end else if (func_t'(op_r.func) == FUNC_UPSERT && rd_key_r == op_r.key) begin
            wr_en = 1'b1;
            rsp_nxt.status     = ST_REPLACED;
            rsp_nxt.slot_index = SlotW'(idx_r);
            state_nxt = B_OUT;
          end else if (next_idx == home_r) begin
            rsp_nxt.status = ST_FULL;
            state_nxt = B_OUT;
          end else begin
            state_nxt = B_READ;
          end
        end
      end
      B_WIPE: begin
        rsp_nxt.status      = ST_CLEARED;
        rsp_nxt.read_value  = '0;
        rsp_nxt.slot_index  = '0;
        rsp_nxt.entry_total = '0;
        state_nxt = B_OUT;
      end
      B_OUT: if (!ovalid_r || out_ch.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // memory read and write ports
  always_ff @(posedge clk) begin
    if (state_r == B_READ) begin
      rd_key_r <= key_mem[idx_r];
      rd_val_r <= val_mem[idx_r];
    end
    if (ins_en) key_mem[idx_r] <= op_r.key;
    if (wr_en)  val_mem[idx_r] <= op_r.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      used_r   <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_WIPE) begin
        used_r  <= '0;
        count_r <= '0;
      end
      if (ins_en) begin
        used_r[idx_r] <= 1'b1;
        count_r       <= count_r + 1'b1;
      end
      if (state_r == B_OUT && (!ovalid_r || out_ch.ready)) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r   <= q_req;
      idx_r  <= q_home;
      home_r <= q_home;
    end else if (state_r == B_CHECK && state_nxt == B_READ) begin
      idx_r <= next_idx;
    end
    if (state_r == B_READ) rd_used_r <= used_r[idx_r];
    if (state_r == B_CHECK || state_r == B_WIPE) rsp_r <= rsp_nxt;
    if (state_r == B_OUT && (!ovalid_r || out_ch.ready)) begin
      out_ch.status      <= rsp_r.status;
      out_ch.read_value  <= rsp_r.read_value;
      out_ch.slot_index  <= rsp_r.slot_index;
      out_ch.entry_total <= rsp_r.entry_total;
    end
  end

  assign out_ch.valid = ovalid_r;

endmodule

// ----- rtl/core/linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with FNV-1a hashing and linear probing.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | func, key, value
//  out_    | out | status, read_value, slot_index, entry_total
//  cfg_    | in  | load_limit write
//
// The front end hashes the key one multiply a cycle. The back end reads,
// then compares, each probed slot (B_READ, B_CHECK) and finishes in B_OUT;
// clear goes through B_WIPE and B_OUT. Front and back overlap via a
// two-entry queue. Reset is synchronous; no clearing pass is needed, slot
// occupancy resets at once. Results wait in an output register under stall.
module linear_probe_hash_table #(
  parameter int unsigned SLOTS     = 256,
  parameter int unsigned KEY_BYTES = 4,
  parameter int unsigned VAL_BYTES = 4
) (
  input  logic clk,
  input  logic rst_n,
  lpht_req_if.sink   in_ch,
  lpht_rsp_if.source out_ch,
  input  logic                        cfg_we,
  input  logic [lpht_pkg::LimitW-1:0] cfg_wdata
);
  import lpht_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [LimitW-1:0] limit_r;
  logic              q_valid, q_pop;
  req_t              q_req;
  logic [IdxW-1:0]   q_home;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LimitReset;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  lpht_front #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES), .VAL_BYTES(VAL_BYTES)) u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_pop, .q_req, .q_home
  );

  lpht_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_req, .q_home,
    .load_limit(limit_r), .out_ch
  );

endmodule

// ----- rtl/core/lpht_checker.sv -----
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks on the hash table result channel.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_macros.svh"

module lpht_sva (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] out_status,
  input logic [7:0] out_slot_index,
  input logic [8:0] out_entry_total
);
  import lpht_pkg::*;

  `LPHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "result dropped under stall")
  `LPHT_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_status <= 3'(ST_CLEARED), "status code out of range")
  `LPHT_ASSERT_IMP(a_clear_empty, clk, rst_n, out_valid && out_status == 3'(ST_CLEARED), out_entry_total == 9'd0 && out_slot_index == 8'd0, "clear left entries")
  `LPHT_ASSERT_IMP(a_total_max, clk, rst_n, out_valid, out_entry_total <= 9'd256, "entry total beyond capacity")

endmodule

bind linear_probe_hash_table lpht_sva u_lpht_sva (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_slot_index(out_ch.slot_index),
  .out_entry_total(out_ch.entry_total)
);
